### hdl/eqf_pkg.sv
`default_nettype none

package eqf_pkg;

    localparam int DIM_W = 6;
    localparam int VAL_W = 32;
    localparam int ROW_W = 5;
    localparam int ACT_W = 2;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

    localparam logic [ACT_W-1:0] ACT_MATRIX = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CENTER = 2'd1;
    localparam logic [ACT_W-1:0] ACT_POINT  = 2'd2;

    localparam logic REG_DIM = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_ROW,
        S_WAIT,
        S_FMUL,
        S_FACC,
        S_FORM
    } t_state;

endpackage

`default_nettype wire

### hdl/eqf_regs.sv
`default_nettype none

module eqf_regs (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [eqf_pkg::APB_AW-1:0]  paddr,
    input  wire  [eqf_pkg::APB_DW-1:0]  pwdata,
    output logic [eqf_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [eqf_pkg::DIM_W-1:0]   o_dim
);
    import eqf_pkg::*;

    logic [DIM_W-1:0] r_dim;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_DIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_RESET;
        end else if (wr_en) begin
            r_dim <= pwdata[DIM_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_DIM) begin
            prdata = APB_DW'(r_dim);
        end
    end

    assign o_dim = r_dim;

endmodule

`default_nettype wire

### hdl/ellipsoid_quadratic_form.sv
`default_nettype none

// Ellipsoid quadratic form engine. Matrix entries (action 0) and center entries
// (action 1) are written into on-chip RAM in the cycle they are taken; busy stays
// low. A point element (action 2) with index below the effective dimension n holds
// busy for one cycle while x - a is stored; elements with index n or above are
// dropped. The element with index n-1 starts the evaluation: one shared 32x33
// multiplier walks the matrix RAM one entry per cycle, row by row, with busy high
// for the whole run. Results come out as o_index/o_result/o_last with a one-cycle
// o_valid strobe: c[0..n-1], one word per row, then the form value d.c - 1 with
// o_last set. The receiver cannot stall, so every strobed word must be captured.
// All values are signed Q(31-FRAC_BITS).FRAC_BITS, floored and saturated to
// 32 bits. dim (register 0) must only be written while busy is low and no run
// is open.

module ellipsoid_quadratic_form #(
    parameter int MAX_DIM   = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  [eqf_pkg::ACT_W-1:0]    i_action,
    input  wire  [eqf_pkg::ROW_W-1:0]    i_row,
    input  wire  [eqf_pkg::ROW_W-1:0]    i_col,
    input  wire  signed [eqf_pkg::VAL_W-1:0] i_value,
    output logic                         o_valid,
    output logic [eqf_pkg::DIM_W-1:0]    o_index,
    output logic signed [eqf_pkg::VAL_W-1:0] o_result,
    output logic                         o_last,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [eqf_pkg::APB_AW-1:0]   paddr,
    input  wire  [eqf_pkg::APB_DW-1:0]   pwdata,
    output logic [eqf_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import eqf_pkg::*;

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int MDEP  = MAX_DIM * MAX_DIM;
    localparam int AW    = (MDEP > 1) ? $clog2(MDEP) : 1;
    localparam int DW    = VAL_W + 1;
    localparam int PW    = VAL_W + DW;
    localparam int ACC_W = PW + DIM_W + 1;

    localparam logic [DIM_W-1:0] MAXD   = DIM_W'(MAX_DIM);
    localparam logic [AW-1:0]    MAXD_A = AW'(MAX_DIM);
    localparam logic [ACC_W-1:0] FORM_INIT = {ACC_W{1'b1}} << (2 * FRAC_BITS);

    function automatic logic [VAL_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        logic [ACC_W-VAL_W:0]    top;
        logic [VAL_W-1:0]        res;
        s   = v >>> FRAC_BITS;
        top = s[ACC_W-1:VAL_W-1];
        if (top == '0 || top == '1) begin
            res = s[VAL_W-1:0];
        end else if (s[ACC_W-1]) begin
            res = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return res;
    endfunction

    // configuration
    logic [DIM_W-1:0] dim;
    logic [DIM_W-1:0] n_eff;
    logic [DIM_W-1:0] n_last;

    eqf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_dim   (dim)
    );

    always_comb begin
        if (dim == '0) begin
            n_eff = DIM_W'(1);
        end else if (dim > MAXD) begin
            n_eff = MAXD;
        end else begin
            n_eff = dim;
        end
        n_last = n_eff - DIM_W'(1);
    end

    // memories
    logic [VAL_W-1:0] mem_a [0:MDEP-1];
    logic [VAL_W-1:0] mem_c [0:MAX_DIM-1];
    logic [DW-1:0]    mem_d [0:MAX_DIM-1];

    logic signed [VAL_W-1:0] r_a_q;
    logic signed [VAL_W-1:0] r_cen_q;
    logic signed [DW-1:0]    r_d_q;

    // control
    t_state r_state, n_state;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_j, n_j;
    logic          r_v1, r_v2, r_last1, r_last2, r_eq1, r_done;
    logic          r_out_valid, n_out_valid;
    logic [DIM_W-1:0] r_out_index, n_out_index;
    logic [VAL_W-1:0] r_out_result, n_out_result;
    logic          r_out_last, n_out_last;

    // payload
    logic [IW-1:0]           r_col;
    logic signed [VAL_W-1:0] r_val;
    logic signed [DW-1:0]    r_di;
    logic signed [VAL_W-1:0] r_c;
    logic signed [PW-1:0]    r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] r_form;

    logic          accept;
    logic          wr_a, wr_c, go_point, run_start;
    logic [AW-1:0] wr_a_addr, rd_a_addr;
    logic signed [DW-1:0]    diff;
    logic signed [VAL_W-1:0] mul_a;
    logic signed [DW-1:0]    mul_b;
    logic [VAL_W-1:0]        c_sat;

    assign accept    = start && !busy;
    assign wr_a      = accept && (i_action == ACT_MATRIX) &&
                       (DIM_W'(i_row) < MAXD) && (DIM_W'(i_col) < MAXD);
    assign wr_c      = accept && (i_action == ACT_CENTER) && (DIM_W'(i_col) < MAXD);
    assign go_point  = accept && (i_action == ACT_POINT) && (DIM_W'(i_col) < n_eff);
    assign run_start = (r_state == S_DIFF) && (DIM_W'(r_col) == n_last);

    assign wr_a_addr = AW'(IW'(i_row)) * MAXD_A + AW'(IW'(i_col));
    assign rd_a_addr = AW'(r_i) * MAXD_A + AW'(r_j);
    assign diff      = $signed({r_val[VAL_W-1], r_val}) - $signed({r_cen_q[VAL_W-1], r_cen_q});
    assign c_sat     = sat_out(r_acc);

    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            mem_a[wr_a_addr] <= i_value;
        end
        r_a_q <= mem_a[rd_a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_c) begin
            mem_c[IW'(i_col)] <= i_value;
        end
        r_cen_q <= mem_c[IW'(i_col)];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIFF) begin
            mem_d[r_col] <= diff;
        end
        r_d_q <= mem_d[r_j];
    end

    // shared multiplier: matrix row pass, then c[i] * d[i]
    always_comb begin
        if (r_state == S_FMUL) begin
            mul_a = r_c;
            mul_b = r_di;
        end else begin
            mul_a = r_a_q;
            mul_b = r_d_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(mul_a) * PW'(mul_b);
        if (accept) begin
            r_col <= IW'(i_col);
            r_val <= i_value;
        end
        if (r_v1 && r_eq1) begin
            r_di <= r_d_q;
        end
        if (r_state == S_WAIT && r_done) begin
            r_c <= c_sat;
        end
        if (run_start || r_state == S_FACC) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (run_start) begin
            r_form <= FORM_INIT;
        end else if (r_state == S_FACC) begin
            r_form <= r_form + ACC_W'(r_prod);
        end
        r_last1 <= DIM_W'(r_j) == n_last;
        r_eq1   <= r_j == r_i;
        r_last2 <= r_last1;
        r_out_index  <= n_out_index;
        r_out_result <= n_out_result;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_v1        <= r_state == S_ROW;
            r_v2        <= r_v1;
            r_done      <= r_v2 && r_last2;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_i          = r_i;
        n_j          = r_j;
        n_out_valid  = 1'b0;
        n_out_index  = r_out_index;
        n_out_result = r_out_result;
        n_out_last   = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (go_point) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                if (run_start) begin
                    n_state = S_ROW;
                    n_i     = '0;
                    n_j     = '0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ROW: begin
                if (DIM_W'(r_j) == n_last) begin
                    n_state = S_WAIT;
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            S_WAIT: begin
                if (r_done) begin
                    n_state      = S_FMUL;
                    n_out_valid  = 1'b1;
                    n_out_index  = DIM_W'(r_i);
                    n_out_result = c_sat;
                    n_out_last   = 1'b0;
                end
            end
            S_FMUL: begin
                n_state = S_FACC;
            end
            S_FACC: begin
                if (DIM_W'(r_i) == n_last) begin
                    n_state = S_FORM;
                end else begin
                    n_state = S_ROW;
                    n_i     = r_i + IW'(1);
                    n_j     = '0;
                end
            end
            S_FORM: begin
                n_state      = S_IDLE;
                n_out_valid  = 1'b1;
                n_out_index  = n_eff;
                n_out_result = sat_out(r_form);
                n_out_last   = 1'b1;
            end
        endcase
    end

    assign busy     = r_state != S_IDLE;
    assign o_valid  = r_out_valid;
    assign o_index  = r_out_index;
    assign o_result = r_out_result;
    assign o_last   = r_out_last;

    // strobes are never adjacent
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result strobes");

    // form value closes the run
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("form value while still busy");

    // row results only inside a run
    a_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("row result outside a run");

    // no product may enter the accumulator during the form step
    a_mac_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FMUL || r_state == S_FACC) |-> (!r_v1 && !r_v2))
        else $error("row pipeline still busy during form step");

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

    import eqf_pkg::*;

    localparam int MAX_DIM    = 32;
    localparam int FRAC       = 16;
    localparam int SEQ_ITEMS  = 390;
    localparam int IDLE_LIMIT = 2000;

    localparam logic [ACT_W-1:0]  ACT_NONE = 2'd3;
    localparam logic [APB_AW-1:0] DIM_ADDR = APB_AW'(4 * REG_DIM);

    localparam logic signed [VAL_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct {
        logic [DIM_W-1:0]        index;
        logic signed [VAL_W-1:0] result;
        logic                    last;
    } t_form_word;

    logic                    i_clk    = 1'b0;
    logic                    i_rst_n  = 1'b0;
    logic                    start    = 1'b0;
    logic [ACT_W-1:0]        i_action = '0;
    logic [ROW_W-1:0]        i_row    = '0;
    logic [ROW_W-1:0]        i_col    = '0;
    logic signed [VAL_W-1:0] i_value  = '0;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [APB_AW-1:0]       paddr    = '0;
    logic [APB_DW-1:0]       pwdata   = '0;

    wire                     busy;
    wire                     o_valid;
    wire [DIM_W-1:0]         o_index;
    wire signed [VAL_W-1:0]  o_result;
    wire                     o_last;
    wire [APB_DW-1:0]        prdata;
    wire                     pready;

    // shadow copy of the block's state
    logic signed [VAL_W-1:0] a_mem [MAX_DIM*MAX_DIM];
    logic signed [VAL_W-1:0] c_mem [MAX_DIM];
    logic signed [VAL_W:0]   d_mem [MAX_DIM];
    bit                      a_set [MAX_DIM*MAX_DIM];
    bit                      c_set [MAX_DIM];
    bit                      d_set [MAX_DIM];
    logic [DIM_W-1:0]        dim_reg = DIM_RESET;

    t_form_word form_words_q[$];

    int err_count     = 0;
    int items_sent    = 0;
    int words_checked = 0;
    int runs_done     = 0;
    int idle_cycles   = 0;
    bit gaps_on       = 1'b0;

    ellipsoid_quadratic_form #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_action (i_action),
        .i_row    (i_row),
        .i_col    (i_col),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .o_index  (o_index),
        .o_result (o_result),
        .o_last   (o_last),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] d);
        if (d == 0) return 1;
        if (d > MAX_DIM) return MAX_DIM;
        return int'(d);
    endfunction

    // floor to Q16.16, then clamp to 32 bits
    function automatic logic signed [VAL_W-1:0] floor_sat(input logic signed [127:0] acc);
        logic signed [127:0] s;
        s = acc >>> FRAC;
        if (s > 128'sh7FFF_FFFF) return Q_MAX;
        if (s < -128'sh8000_0000) return Q_MIN;
        return s[VAL_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value(input int wide_pct);
        if ($urandom_range(0, 99) < wide_pct) begin
            case ($urandom_range(0, 2))
                0: return Q_MAX;
                1: return Q_MIN;
                default: return $urandom;
            endcase
        end
        return int'($urandom_range(0, 6 * 65536)) - 3 * 65536;
    endfunction

    task automatic compute_form_words(input logic [ACT_W-1:0] act, input logic [ROW_W-1:0] r,
                                      input logic [ROW_W-1:0] c,
                                      input logic signed [VAL_W-1:0] v);
        int                      n;
        logic signed [127:0]     row_acc;
        logic signed [127:0]     form_acc;
        logic signed [VAL_W-1:0] ci;
        t_form_word              w;
        n = eff_dim(dim_reg);
        case (act)
            ACT_MATRIX: begin
                a_mem[r * MAX_DIM + c] = v;
                a_set[r * MAX_DIM + c] = 1'b1;
                items_sent++;
            end
            ACT_CENTER: begin
                c_mem[c] = v;
                c_set[c] = 1'b1;
                items_sent++;
            end
            ACT_POINT: begin
                if (c < n) begin
                    items_sent++;
                    d_mem[c] = (VAL_W + 1)'(v) - (VAL_W + 1)'(c_mem[c]);
                    d_set[c] = 1'b1;
                    if (c == n - 1) begin
                        form_acc = -(128'sd1 <<< (2 * FRAC));
                        for (int i = 0; i < n; i++) begin
                            row_acc = '0;
                            for (int j = 0; j < n; j++)
                                row_acc = row_acc + 128'(a_mem[i * MAX_DIM + j]) *
                                          128'(d_mem[j]);
                            ci = floor_sat(row_acc);
                            form_acc = form_acc + 128'(ci) * 128'(d_mem[i]);
                            w.index  = DIM_W'(i);
                            w.result = ci;
                            w.last   = 1'b0;
                            form_words_q.push_back(w);
                        end
                        w.index  = DIM_W'(n);
                        w.result = floor_sat(form_acc);
                        w.last   = 1'b1;
                        form_words_q.push_back(w);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input logic [ACT_W-1:0] act, input logic [ROW_W-1:0] r,
                             input logic [ROW_W-1:0] c, input logic signed [VAL_W-1:0] v);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_action <= act;
        i_row    <= r;
        i_col    <= c;
        i_value  <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        compute_form_words(act, r, c, v);
    endtask

    task automatic drain_block;
        start <= 1'b0;
        while (form_words_q.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DIM_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        dim_reg = data[DIM_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read_check;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= DIM_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== APB_DW'(dim_reg)) begin
            $error("prdata: expected %0d, got %0d", dim_reg, prdata);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_dim(input logic [APB_DW-1:0] data);
        drain_block();
        apb_write(data);
        apb_read_check();
    endtask

    task automatic load_matrix(input int n);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (!a_set[i * MAX_DIM + j])
                    send_word(ACT_MATRIX, ROW_W'(i), ROW_W'(j), pick_value(n > 8 ? 2 : 10));
        repeat ($urandom_range(0, 4))
            send_word(ACT_MATRIX, ROW_W'($urandom_range(0, n - 1)),
                      ROW_W'($urandom_range(0, n - 1)), pick_value(10));
    endtask

    task automatic load_centers(input int n);
        for (int k = 0; k < n; k++)
            if (!c_set[k])
                send_word(ACT_CENTER, ROW_W'($urandom), ROW_W'(k), pick_value(10));
        repeat ($urandom_range(0, 2))
            send_word(ACT_CENTER, ROW_W'($urandom), ROW_W'($urandom_range(0, n - 1)),
                      pick_value(10));
    endtask

    task automatic send_noise(input int n);
        case ($urandom_range(0, 3))
            0: send_word(ACT_NONE, ROW_W'($urandom), ROW_W'($urandom), $urandom);
            1: send_word(ACT_POINT, ROW_W'($urandom),
                         ROW_W'(n < MAX_DIM ? $urandom_range(n, MAX_DIM - 1) : 0), $urandom);
            2: send_word(ACT_MATRIX, ROW_W'($urandom), ROW_W'($urandom), pick_value(10));
            default: send_word(ACT_CENTER, ROW_W'($urandom), ROW_W'($urandom), pick_value(10));
        endcase
    endtask

    // elements below n-1 in random order, some kept from the last point, then n-1
    task automatic send_point(input int n);
        int order [MAX_DIM];
        int cnt;
        int pick;
        int tmp;
        cnt = 0;
        for (int k = 0; k < n - 1; k++)
            if (!d_set[k] || $urandom_range(0, 3) != 0) begin
                order[cnt] = k;
                cnt++;
            end
        for (int k = cnt - 1; k > 0; k--) begin
            pick        = $urandom_range(0, k);
            tmp         = order[k];
            order[k]    = order[pick];
            order[pick] = tmp;
        end
        for (int k = 0; k < cnt; k++) begin
            if ($urandom_range(0, 5) == 0) send_noise(n);
            send_word(ACT_POINT, ROW_W'($urandom), ROW_W'(order[k]), pick_value(5));
        end
        send_word(ACT_POINT, ROW_W'($urandom), ROW_W'(n - 1), pick_value(5));
    endtask

    task automatic test_register;
        apb_read_check();
        apb_write(32'hFFFF_FFC0);
        apb_read_check();
        apb_write(32'h0000_003F);
        apb_read_check();
    endtask

    task automatic test_directed;
        set_dim(32'hFFFF_FFC0);
        send_word(ACT_MATRIX, 5'd0, 5'd0, Q_MAX);
        send_word(ACT_CENTER, 5'd31, 5'd0, Q_MIN);
        send_word(ACT_POINT, 5'd0, 5'd31, Q_ONE);
        send_word(ACT_NONE, 5'd31, 5'd31, Q_MIN);
        send_word(ACT_POINT, 5'd0, 5'd0, Q_MAX);
        send_word(ACT_POINT, 5'd0, 5'd0, Q_MIN);
        send_word(ACT_MATRIX, 5'd0, 5'd0, Q_MIN);
        send_word(ACT_CENTER, 5'd0, 5'd0, Q_MAX);
        send_word(ACT_POINT, 5'd31, 5'd0, Q_MIN);
        set_dim(32'd2);
        send_word(ACT_MATRIX, 5'd0, 5'd0, Q_ONE);
        send_word(ACT_MATRIX, 5'd0, 5'd1, Q_ONE);
        send_word(ACT_MATRIX, 5'd1, 5'd0, -Q_ONE);
        send_word(ACT_MATRIX, 5'd1, 5'd1, 2 * Q_ONE);
        send_word(ACT_CENTER, 5'd0, 5'd1, Q_ONE / 2);
        send_word(ACT_POINT, 5'd0, 5'd1, Q_ONE);
        send_word(ACT_POINT, 5'd0, 5'd0, -Q_ONE);
        send_word(ACT_POINT, 5'd0, 5'd1, 3 * Q_ONE / 2);
        send_word(ACT_POINT, 5'd0, 5'd1, 32'sd0);
        send_word(ACT_POINT, 5'd0, 5'd2, Q_ONE);
        send_word(ACT_MATRIX, 5'd31, 5'd31, 32'sd0);
    endtask

    task automatic test_random;
        int                base;
        int                n;
        logic [DIM_W-1:0]  d;
        logic [APB_DW-1:0] wdata;
        base = items_sent;
        while (items_sent < base + SEQ_ITEMS) begin
            case ($urandom_range(0, 19))
                0: d = '0;
                2, 3, 4: d = DIM_W'($urandom_range(9, 12));
                default: d = DIM_W'($urandom_range(1, 8));
            endcase
            wdata = $urandom_range(0, 1) ? $urandom : '0;
            wdata[DIM_W-1:0] = d;
            set_dim(wdata);
            n = eff_dim(dim_reg);
            gaps_on = (items_sent - base < SEQ_ITEMS - 80) && ($urandom_range(0, 3) != 0);
            load_matrix(n);
            load_centers(n);
            repeat ($urandom_range(1, 3)) send_point(n);
        end
    endtask

    always @(posedge i_clk) begin : check_words
        t_form_word want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (form_words_q.size() == 0) begin
                $error("o_valid: unexpected word, index %0d result %h", o_index, o_result);
                err_count++;
            end else begin
                want = form_words_q.pop_front();
                words_checked++;
                if (want.last) runs_done++;
                if (o_index !== want.index) begin
                    $error("o_index: expected %0d, got %0d", want.index, o_index);
                    err_count++;
                end
                if (o_result !== want.result) begin
                    $error("o_result: expected %h, got %h", want.result, o_result);
                    err_count++;
                end
                if (o_last !== want.last) begin
                    $error("o_last: expected %0d, got %0d", want.last, o_last);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid === 1'b1 || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gaps_on = 1'b1;
        test_register();
        test_directed();
        test_random();
        drain_block();
        repeat (64) @(posedge i_clk);
        if (form_words_q.size() != 0) begin
            $error("o_valid: %0d words never arrived", form_words_q.size());
            err_count++;
        end
        $display("tb: %0d words sent, %0d result words checked in %0d evaluations",
                 items_sent, words_checked, runs_done);
        $display("tb: dims 0 to 12, saturation at both ends, dropped and unused words");
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/eqf_pkg.sv
hdl/eqf_regs.sv
hdl/ellipsoid_quadratic_form.sv
dv/tb.sv
